// ===== src/ptw4_pkg.sv =====
`timescale 1ns / 1ps
package ptw4_pkg;

  // Defaults and fixed geometry of the table store
  localparam int TABLE_SLOTS_DEF   = 16;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int IDX_W             = 9;
  localparam int ADDR_BITS         = 52;
  localparam int ENTRY_W           = 64;
  localparam int FLAG_W            = 12;

  // Opcodes
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_MAP  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_MISALIGNED = 2'd1;
  localparam logic [1:0] ST_RANGE      = 2'd2;
  localparam logic [1:0] ST_UNMAPPED   = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_ROOT_VALID = 2'd0;
  localparam logic [1:0] CFG_ROOT_SLOT  = 2'd1;

  localparam logic [1:0] LEAF_LEVEL = 2'd3;

  typedef struct packed {
    logic [1:0]           opcode;
    logic [ADDR_BITS-1:0] guest_addr;
    logic [ADDR_BITS-1:0] host_addr;
    logic [FLAG_W-1:0]    leaf_flags_in;
    logic [3:0]           load_slot;
    logic [IDX_W-1:0]     load_index;
    logic [ENTRY_W-1:0]   load_word;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [FLAG_W-1:0] leaf_flags_out;
  } out_item_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RED,
    S_ISSUE,
    S_CHECK
  } state_t;

endpackage

// ===== src/four_level_page_table_walker_core.sv =====
`timescale 1ns / 1ps
// Flow (power-of-two TABLE_SLOTS): load writes its entry in S_ISSUE; map and read visit S_ISSUE
//   and S_CHECK per level, but map ends on its leaf write. Rejects (no root, misaligned, range,
//   unused opcode) finish from S_IDLE. The next item may start in the strobe cycle. Other slot
//   counts add S_RED per slot, one nibble a cycle. Single-port table memory: one access a cycle.
// Reset: clears the whole store, one entry a cycle, with busy high.
// The receiver cannot stall: out_valid marks each result for exactly one cycle.
module four_level_page_table_walker_core #(
  parameter int TABLE_SLOTS = ptw4_pkg::TABLE_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ptw4_pkg::in_item_t  in_item,
  output logic                out_valid,
  output ptw4_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [3:0]          cfg_data
);

  localparam int SLOT_W  = $clog2(TABLE_SLOTS);
  localparam int ADDR_W  = SLOT_W + ptw4_pkg::IDX_W;
  localparam int DEPTH   = TABLE_SLOTS * ptw4_pkg::ENTRIES_PER_TABLE;
  localparam bit IS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
  localparam int DIGITS  = ptw4_pkg::ADDR_BITS / 4;
  localparam int RED_W   = SLOT_W + 4;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [RED_W-1:0]  NDIV      = RED_W'(TABLE_SLOTS);
  localparam logic [3:0]        LAST_DIG  = 4'(DIGITS - 1);

  // Table store: single port, registered read
  logic [ptw4_pkg::ENTRY_W-1:0] mem [DEPTH];
  logic [ptw4_pkg::ENTRY_W-1:0] mem_rdata_r;
  logic                         mem_we;
  logic [ADDR_W-1:0]            mem_addr;
  logic [ptw4_pkg::ENTRY_W-1:0] mem_wdata;

  ptw4_pkg::state_t state_r, state_nxt;

  ptw4_pkg::in_item_t  item_r, item_nxt;
  ptw4_pkg::out_item_t out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic                        root_valid_r;
  logic [3:0]                  root_slot_r;
  logic [1:0]                  level_r, level_nxt;
  logic [SLOT_W-1:0]           slot_r, slot_nxt;
  logic [ADDR_W-1:0]           clr_addr_r, clr_addr_nxt;

  // Shared slot reduction unit (modulo TABLE_SLOTS, one nibble a cycle)
  logic [ptw4_pkg::ADDR_BITS-1:0] red_val_r, red_val_nxt;
  logic [SLOT_W-1:0]              red_rem_r, red_rem_nxt;
  logic [3:0]                     red_cnt_r, red_cnt_nxt;
  logic [RED_W-1:0]               red_t;

  // Sequencer decisions
  logic                           slot_go;
  logic                           src_narrow;
  logic [ptw4_pkg::ADDR_BITS-1:0] red_src;
  logic                           finish;
  logic [1:0]                     fin_status;
  logic [ptw4_pkg::FLAG_W-1:0]    fin_flags;
  logic                           accept;
  logic                           leaf_write;
  logic [ptw4_pkg::IDX_W-1:0]     walk_idx;

  assign busy      = (state_r != ptw4_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Reduce {remainder, next nibble} below TABLE_SLOTS with four compare-subtract steps
  always_comb begin
    red_t = {red_rem_r, red_val_r[ptw4_pkg::ADDR_BITS-1 -: 4]};
    for (int k = 3; k >= 0; k--) begin
      if (red_t >= (NDIV << k)) begin
        red_t = red_t - (NDIV << k);
      end
    end
  end

  // Entry index of the current walk level
  always_comb begin
    case (level_r)
      2'd0:    walk_idx = item_r.guest_addr[47:39];
      2'd1:    walk_idx = item_r.guest_addr[38:30];
      2'd2:    walk_idx = item_r.guest_addr[29:21];
      default: walk_idx = item_r.guest_addr[20:12];
    endcase
  end

  // A leaf write ends the walk for map; load writes its own entry
  assign leaf_write = (item_r.opcode == ptw4_pkg::OP_LOAD) ||
                      (item_r.opcode == ptw4_pkg::OP_MAP && level_r == ptw4_pkg::LEAF_LEVEL);

  // Sequencer decisions: start a slot computation, or finish with a result
  always_comb begin
    slot_go    = 1'b0;
    src_narrow = 1'b0;
    red_src    = '0;
    finish     = 1'b0;
    fin_status = ptw4_pkg::ST_OK;
    fin_flags  = '0;
    case (state_r)
      ptw4_pkg::S_IDLE: begin
        if (accept) begin
          case (in_item.opcode)
            ptw4_pkg::OP_LOAD: begin
              slot_go    = 1'b1;
              src_narrow = 1'b1;
              red_src    = ptw4_pkg::ADDR_BITS'(in_item.load_slot);
            end
            ptw4_pkg::OP_MAP: begin
              if (!root_valid_r) begin
                finish     = 1'b1;
                fin_status = ptw4_pkg::ST_UNMAPPED;
              end else if ((|in_item.guest_addr[11:0]) || (|in_item.host_addr[11:0])) begin
                finish     = 1'b1;
                fin_status = ptw4_pkg::ST_MISALIGNED;
              end else if ((&in_item.guest_addr) || (&in_item.host_addr)) begin
                finish     = 1'b1;
                fin_status = ptw4_pkg::ST_RANGE;
              end else begin
                slot_go    = 1'b1;
                src_narrow = 1'b1;
                red_src    = ptw4_pkg::ADDR_BITS'(root_slot_r);
              end
            end
            ptw4_pkg::OP_READ: begin
              if (!root_valid_r) begin
                finish     = 1'b1;
                fin_status = ptw4_pkg::ST_UNMAPPED;
              end else begin
                slot_go    = 1'b1;
                src_narrow = 1'b1;
                red_src    = ptw4_pkg::ADDR_BITS'(root_slot_r);
              end
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      ptw4_pkg::S_ISSUE: begin
        finish = leaf_write;
      end
      ptw4_pkg::S_CHECK: begin
        if (level_r == ptw4_pkg::LEAF_LEVEL) begin
          finish    = 1'b1;
          fin_flags = mem_rdata_r[ptw4_pkg::FLAG_W-1:0];
        end else if (!mem_rdata_r[0]) begin
          finish     = 1'b1;
          fin_status = ptw4_pkg::ST_UNMAPPED;
        end else begin
          slot_go = 1'b1;
          red_src = mem_rdata_r[ptw4_pkg::ENTRY_W-1:12];
        end
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ptw4_pkg::S_CLEAR: begin
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ptw4_pkg::S_IDLE;
        end
      end
      ptw4_pkg::S_IDLE, ptw4_pkg::S_CHECK: begin
        if (slot_go) begin
          state_nxt = IS_POW2 ? ptw4_pkg::S_ISSUE : ptw4_pkg::S_RED;
        end else if (finish) begin
          state_nxt = ptw4_pkg::S_IDLE;
        end
      end
      ptw4_pkg::S_RED: begin
        if (red_cnt_r == LAST_DIG) begin
          state_nxt = ptw4_pkg::S_ISSUE;
        end
      end
      ptw4_pkg::S_ISSUE: begin
        state_nxt = leaf_write ? ptw4_pkg::S_IDLE : ptw4_pkg::S_CHECK;
      end
      default: begin
        state_nxt = ptw4_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath and memory control
  always_comb begin
    item_nxt      = item_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    level_nxt     = level_r;
    slot_nxt      = slot_r;
    clr_addr_nxt  = clr_addr_r;
    red_val_nxt   = red_val_r;
    red_rem_nxt   = red_rem_r;
    red_cnt_nxt   = red_cnt_r;
    mem_we        = 1'b0;
    mem_addr      = {slot_r, walk_idx};
    mem_wdata     = '0;

    if (accept) begin
      item_nxt  = in_item;
      level_nxt = '0;
    end

    case (state_r)
      ptw4_pkg::S_CLEAR: begin
        mem_we       = 1'b1;
        mem_addr     = clr_addr_r;
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
      ptw4_pkg::S_RED: begin
        red_val_nxt = red_val_r << 4;
        red_rem_nxt = red_t[SLOT_W-1:0];
        red_cnt_nxt = red_cnt_r + 1'b1;
        if (red_cnt_r == LAST_DIG) begin
          slot_nxt = red_t[SLOT_W-1:0];
        end
      end
      ptw4_pkg::S_ISSUE: begin
        if (item_r.opcode == ptw4_pkg::OP_LOAD) begin
          mem_we    = 1'b1;
          mem_addr  = {slot_r, item_r.load_index};
          mem_wdata = item_r.load_word;
        end else if (leaf_write) begin
          mem_we    = 1'b1;
          mem_wdata = {12'b0, item_r.host_addr[ptw4_pkg::ADDR_BITS-1:12],
                       item_r.leaf_flags_in};
        end
      end
      ptw4_pkg::S_CHECK: begin
        if (slot_go) begin
          level_nxt = level_r + 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Start the next slot: direct bit-select, or load the reduction unit
    if (slot_go) begin
      if (IS_POW2) begin
        slot_nxt = red_src[SLOT_W-1:0];
      end else begin
        red_rem_nxt = '0;
        if (src_narrow) begin
          red_val_nxt = {red_src[3:0], (ptw4_pkg::ADDR_BITS - 4)'(0)};
          red_cnt_nxt = LAST_DIG;
        end else begin
          red_val_nxt = red_src;
          red_cnt_nxt = '0;
        end
      end
    end

    if (finish) begin
      out_valid_nxt          = 1'b1;
      out_nxt.status         = fin_status;
      out_nxt.leaf_flags_out = fin_flags;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ptw4_pkg::S_CLEAR;
      out_valid_r  <= 1'b0;
      clr_addr_r   <= '0;
      level_r      <= '0;
      red_cnt_r    <= '0;
      root_valid_r <= 1'b0;
      root_slot_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      clr_addr_r  <= clr_addr_nxt;
      level_r     <= level_nxt;
      red_cnt_r   <= red_cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ptw4_pkg::CFG_ROOT_VALID: root_valid_r <= cfg_data[0];
          ptw4_pkg::CFG_ROOT_SLOT:  root_slot_r  <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    out_r     <= out_nxt;
    slot_r    <= slot_nxt;
    red_val_r <= red_val_nxt;
    red_rem_r <= red_rem_nxt;
  end

  // Table store port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_addr];
  end

endmodule

// ===== tb/four_level_page_table_walker_core_tb.sv =====
`timescale 1ns / 1ps
module four_level_page_table_walker_core_tb;

  localparam int unsigned SLOTS = ptw4_pkg::TABLE_SLOTS_DEF;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] index;
    logic [3:0] data;
  } reg_write_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  ptw4_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  ptw4_pkg::out_item_t out_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = '0;
  logic [3:0]          cfg_data = '0;

  // Shadow copy of the table store and the two root registers
  logic [ptw4_pkg::ENTRY_W-1:0] page_store [SLOTS*ptw4_pkg::ENTRIES_PER_TABLE];
  logic                         root_present = 1'b0;
  logic [3:0]                   root_table = '0;

  ptw4_pkg::in_item_t  pending_items[$];
  ptw4_pkg::out_item_t expected_results[$];
  reg_write_t          reg_writes[$];
  int unsigned         send_gap_pct = 0;
  int                  failures = 0;

  four_level_page_table_walker_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned entry_pos(input logic [3:0] slot,
                                            input logic [ptw4_pkg::IDX_W-1:0] idx);
    return (slot % SLOTS) * ptw4_pkg::ENTRIES_PER_TABLE + idx;
  endfunction

  // Walk the three upper levels; return the leaf position when every pointer is present.
  function automatic bit find_leaf_entry(input logic [ptw4_pkg::ADDR_BITS-1:0] gpa,
                                         output int unsigned leaf);
    int unsigned                  slot;
    logic [ptw4_pkg::ENTRY_W-1:0] ent;
    int                           lvl;
    leaf = 0;
    if (!root_present) return 1'b0;
    slot = root_table % SLOTS;
    for (lvl = 0; lvl < 3; lvl++) begin
      ent = page_store[slot * ptw4_pkg::ENTRIES_PER_TABLE
                       + gpa[39 - 9*lvl +: ptw4_pkg::IDX_W]];
      if (!ent[0]) return 1'b0;
      slot = 32'(ent[ptw4_pkg::ENTRY_W-1:12] % SLOTS);
    end
    leaf = slot * ptw4_pkg::ENTRIES_PER_TABLE + gpa[20:12];
    return 1'b1;
  endfunction

  // Update the shadow store and queue the status/flags the block must return.
  function automatic void predict_walk_result(input ptw4_pkg::in_item_t it);
    ptw4_pkg::out_item_t res;
    int unsigned         leaf;
    res.status = ptw4_pkg::ST_OK;
    res.leaf_flags_out = '0;
    case (it.opcode)
      ptw4_pkg::OP_LOAD: page_store[entry_pos(it.load_slot, it.load_index)] = it.load_word;
      ptw4_pkg::OP_MAP: begin
        if (!root_present)
          res.status = ptw4_pkg::ST_UNMAPPED;
        else if (it.guest_addr[11:0] != '0 || it.host_addr[11:0] != '0)
          res.status = ptw4_pkg::ST_MISALIGNED;
        else if (it.guest_addr == '1 || it.host_addr == '1)
          res.status = ptw4_pkg::ST_RANGE;
        else if (!find_leaf_entry(it.guest_addr, leaf))
          res.status = ptw4_pkg::ST_UNMAPPED;
        else
          page_store[leaf] = {12'h000, it.host_addr[ptw4_pkg::ADDR_BITS-1:12],
                              it.leaf_flags_in};
      end
      ptw4_pkg::OP_READ: begin
        if (!find_leaf_entry(it.guest_addr, leaf))
          res.status = ptw4_pkg::ST_UNMAPPED;
        else
          res.leaf_flags_out = page_store[leaf][ptw4_pkg::FLAG_W-1:0];
      end
      default: ;
    endcase
    expected_results.push_back(res);
  endfunction

  function automatic void apply_reg_write(input logic [1:0] idx, input logic [3:0] data);
    case (idx)
      ptw4_pkg::CFG_ROOT_VALID: root_present = data[0];
      ptw4_pkg::CFG_ROOT_SLOT:  root_table = data;
      default: ;
    endcase
  endfunction

  // Driver: predict on each accepted transfer, then present the next write or item.
  always @(posedge clk) begin : feed
    logic               start_nx;
    logic               cfg_valid_nx;
    ptw4_pkg::in_item_t item_nx;
    reg_write_t         wr;
    logic [1:0]         idx_nx;
    logic [3:0]         data_nx;
    if (!rst_n) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      start_nx = start;
      cfg_valid_nx = cfg_valid;
      item_nx = in_item;
      idx_nx = cfg_index;
      data_nx = cfg_data;
      if (start && !busy) begin
        predict_walk_result(in_item);
        start_nx = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        apply_reg_write(cfg_index, cfg_data);
        cfg_valid_nx = 1'b0;
      end
      // Keep start high across back-to-back items: one assignment per edge.
      if (!start_nx && !cfg_valid_nx) begin
        if (reg_writes.size() != 0) begin
          wr = reg_writes.pop_front();
          cfg_valid_nx = 1'b1;
          idx_nx = wr.index;
          data_nx = wr.data;
        end else if (pending_items.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          start_nx = 1'b1;
          item_nx = pending_items.pop_front();
        end
      end
      start <= start_nx;
      in_item <= item_nx;
      cfg_valid <= cfg_valid_nx;
      cfg_index <= idx_nx;
      cfg_data <= data_nx;
    end
  end

  // Monitor: each strobe is a transfer; compare it with the oldest expectation.
  always @(posedge clk) begin : check
    ptw4_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d flags %h", out_item.status,
               out_item.leaf_flags_out);
        failures++;
      end else begin
        want = expected_results.pop_front();
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_item.status);
          failures++;
        end
        if (out_item.leaf_flags_out !== want.leaf_flags_out) begin
          $error("leaf_flags_out: expected %h, actual %h", want.leaf_flags_out,
                 out_item.leaf_flags_out);
          failures++;
        end
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic ptw4_pkg::in_item_t random_item();
    ptw4_pkg::in_item_t it;
    logic [63:0]        r;
    it.opcode = 2'($urandom_range(3));
    r = rand64();
    it.guest_addr = r[ptw4_pkg::ADDR_BITS-1:0];
    r = rand64();
    it.host_addr = r[ptw4_pkg::ADDR_BITS-1:0];
    it.leaf_flags_in = 12'($urandom_range(4095));
    it.load_slot = 4'($urandom_range(15));
    it.load_index = 9'($urandom_range(511));
    it.load_word = rand64();
    return it;
  endfunction

  function automatic void push_item(input logic [1:0] op,
                                    input logic [ptw4_pkg::ADDR_BITS-1:0] gpa,
                                    input logic [ptw4_pkg::ADDR_BITS-1:0] hpa,
                                    input logic [ptw4_pkg::FLAG_W-1:0] flags,
                                    input logic [3:0] slot,
                                    input logic [ptw4_pkg::IDX_W-1:0] idx,
                                    input logic [63:0] word);
    pending_items.push_back('{op, gpa, hpa, flags, slot, idx, word});
  endfunction

  // Build a present chain from the root down to a leaf table, then map and read through it.
  function automatic int queue_walk_chain(input logic [3:0] root);
    ptw4_pkg::in_item_t             it;
    logic [63:0]                    r;
    logic [ptw4_pkg::ADDR_BITS-1:0] base;
    logic [3:0]                     prev;
    logic [3:0]                     next;
    int                             lvl;
    int                             n;
    int                             k;
    r = rand64();
    base = r[ptw4_pkg::ADDR_BITS-1:0];
    prev = root;
    for (lvl = 0; lvl < 3; lvl++) begin
      it = random_item();
      it.opcode = ptw4_pkg::OP_LOAD;
      it.load_slot = prev;
      it.load_index = base[39 - 9*lvl +: ptw4_pkg::IDX_W];
      next = 4'($urandom_range(15));
      r = rand64();
      r[15:12] = next;
      r[0] = 1'b1;
      it.load_word = r;
      pending_items.push_back(it);
      prev = next;
    end
    n = $urandom_range(1, 4);
    for (k = 0; k < n; k++) begin
      it = random_item();
      it.opcode = $urandom_range(1) ? ptw4_pkg::OP_MAP : ptw4_pkg::OP_READ;
      it.guest_addr[ptw4_pkg::ADDR_BITS-1:21] = base[ptw4_pkg::ADDR_BITS-1:21];
      if ($urandom_range(1)) it.guest_addr[20:12] = base[20:12];
      // Mostly aligned maps so the walk is reached; some fall to the alignment check.
      if (it.opcode == ptw4_pkg::OP_MAP && $urandom_range(9) != 0) begin
        it.guest_addr[11:0] = '0;
        it.host_addr[11:0] = '0;
      end
      pending_items.push_back(it);
    end
    return 3 + n;
  endfunction

  function automatic ptw4_pkg::in_item_t noise_item();
    ptw4_pkg::in_item_t it;
    it = random_item();
    if (it.opcode == ptw4_pkg::OP_MAP && $urandom_range(1)) begin
      it.guest_addr[11:0] = '0;
      it.host_addr[11:0] = '0;
    end
    return it;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [3:0] data);
    reg_writes.push_back('{idx, data});
    do @(negedge clk); while (reg_writes.size() != 0 || cfg_valid);
  endtask

  // Poll on the falling edge so every nonblocking update of the rising edge has landed.
  task automatic wait_drain();
    while (pending_items.size() != 0 || start || expected_results.size() != 0)
      @(negedge clk);
  endtask

  initial begin : stimulus
    logic [3:0] phase_root;
    logic       phase_valid;
    int         ph;
    int         queued;
    foreach (page_store[i]) page_store[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // Hold off until the store has been cleared.
    while (busy !== 1'b0) @(negedge clk);

    send_gap_pct = 10;
    // No root yet: every walk reports not mapped, loads still land.
    write_reg(ptw4_pkg::CFG_ROOT_VALID, 4'h0);
    write_reg(ptw4_pkg::CFG_ROOT_SLOT, 4'h0);
    push_item(ptw4_pkg::OP_MAP, '0, '0, '0, '0, '0, '0);
    push_item(ptw4_pkg::OP_READ, '0, '0, '0, '0, '0, '0);
    push_item(OP_UNUSED, '1, '1, '1, '1, '1, '1);
    push_item(ptw4_pkg::OP_LOAD, '0, '0, '0, 4'd0, 9'd0, 64'h1001);
    wait_drain();

    write_reg(ptw4_pkg::CFG_ROOT_VALID, 4'h1);
    push_item(ptw4_pkg::OP_MAP, 52'h1, '0, '0, '0, '0, '0);
    push_item(ptw4_pkg::OP_MAP, '0, 52'h800, '0, '0, '0, '0);
    push_item(ptw4_pkg::OP_READ, '0, '0, '0, '0, '0, '0);
    push_item(ptw4_pkg::OP_LOAD, '0, '0, '0, 4'd1, 9'd0, 64'h2001);
    push_item(ptw4_pkg::OP_LOAD, '0, '0, '0, 4'd2, 9'd0, 64'h3001);
    // Leaf is returned even though its present bit is clear.
    push_item(ptw4_pkg::OP_READ, '0, '0, '0, '0, '0, '0);
    push_item(ptw4_pkg::OP_MAP, '0, 52'hFFFFF_FFFF_F000, 12'hFFF, '0, '0, '0);
    push_item(ptw4_pkg::OP_READ, 52'hFFF, '0, '0, '0, '0, '0);
    // Bits above 47 take no part in the walk.
    push_item(ptw4_pkg::OP_MAP, 52'hF_0000_0000_0000, '0, '0, '0, '0, '0);
    push_item(ptw4_pkg::OP_READ, '0, '0, '0, '0, '0, '0);
    push_item(ptw4_pkg::OP_LOAD, '0, '0, '0, 4'd15, 9'd511, '1);
    wait_drain();

    // Top slot, top indexes: one entry serves all four levels.
    write_reg(ptw4_pkg::CFG_ROOT_SLOT, 4'hF);
    push_item(ptw4_pkg::OP_READ, '1, '0, '0, '0, '0, '0);
    push_item(ptw4_pkg::OP_MAP, 52'hFFFFF_FFFF_F000, 52'h1000, 12'h800, '0, '0, '0);
    push_item(ptw4_pkg::OP_READ, '1, '0, '0, '0, '0, '0);
    push_item(ptw4_pkg::OP_MAP, '0, '1, '0, '0, '0, '0);
    push_item(ptw4_pkg::OP_MAP, '0, 52'h5000, 12'h001, '0, '0, '0);
    push_item(ptw4_pkg::OP_LOAD, '0, '0, '0, 4'd15, 9'd511, '0);
    wait_drain();

    for (ph = 0; ph < 6; ph++) begin
      send_gap_pct = (ph < 2) ? 10 : (ph < 4) ? 70 : 0;
      case (ph)
        0, 5: phase_root = 4'hF;
        2: phase_root = 4'h0;
        default: phase_root = 4'($urandom_range(15));
      endcase
      phase_valid = (ph != 3);
      // Upper data bits of the valid register are ignored.
      write_reg(ptw4_pkg::CFG_ROOT_VALID, {3'($urandom_range(7)), phase_valid});
      write_reg(ptw4_pkg::CFG_ROOT_SLOT, phase_root);
      queued = 0;
      while (queued < 313) begin
        if ($urandom_range(99) < 80) begin
          queued += queue_walk_chain(phase_root);
        end else begin
          pending_items.push_back(noise_item());
          queued++;
        end
      end
      wait_drain();
    end

    repeat (20) @(negedge clk);
    if (failures == 0) begin
      $display("[four_level_page_table_walker_core] OK");
    end else begin
      $display("[four_level_page_table_walker_core] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("[four_level_page_table_walker_core] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
src/ptw4_pkg.sv
src/four_level_page_table_walker_core.sv
tb/four_level_page_table_walker_core_tb.sv
